@@ rtl/thc_pkg.sv @@
package thc_pkg;

  // Geometry of the conversion table and of the fixed-point temperature.
  localparam int TablePoints = 20;
  localparam int FracBits    = 4;
  localparam int SegW        = $clog2(TablePoints);

  // Field widths.
  localparam int CmdW     = 2;
  localparam int AdcW     = 10;
  localparam int TempW    = 14;
  localparam int ModeW    = 3;
  localparam int DutyW    = 7;
  localparam int CntW     = 8;
  localparam int GlitchW  = 3;
  localparam int TargetW  = 8;
  localparam int AccW     = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  // Every table segment spans the same number of converter counts.
  localparam int SegSpan = 53;
  localparam int DxW     = $clog2(SegSpan + 2);

  // Division by the span is done as a multiplication by a scaled reciprocal.
  // The rounding error of the reciprocal times the largest numerator stays
  // below two to the shift, so the quotient is exact.
  localparam int     RecipShift = 25;
  localparam longint RecipMul   =
    ((longint'(1) << RecipShift) + longint'(SegSpan) - 1) / longint'(SegSpan);
  localparam int     CoefW      = 34;

  // Controller constants.
  localparam logic [AdcW-1:0]    GlitchLevel  = 10'd990;
  localparam logic [GlitchW-1:0] GlitchMax    = 3'd4;
  localparam logic [GlitchW-1:0] GlitchLimit  = 3'd3;
  localparam logic [DutyW-1:0]   FullCount    = 7'd100;
  localparam logic [DutyW-1:0]   ThirdCount   = DutyW'(100 / 3);
  localparam logic [CntW-1:0]    PreheatLimit = 8'd3;
  localparam logic [CntW-1:0]    CoolLimit    = 8'd10;
  localparam logic [CntW-1:0]    HeatLimit    = 8'd75;

  // Register reset values.
  localparam logic [TargetW-1:0] TargetReset = 8'd0;
  localparam logic [TargetW-1:0] RoomReset   = 8'd30;
  localparam logic [AccW-1:0]    AccReset    = 5'd5;

  typedef enum logic [CmdW-1:0] {
    CmdAdcSample   = 2'd0,
    CmdControlTick = 2'd1,
    CmdPwmTick     = 2'd2
  } cmd_e;

  typedef enum logic [ModeW-1:0] {
    ModeOff     = 3'd0,
    ModePreheat = 3'd1,
    ModeStable  = 3'd2,
    ModeCool    = 3'd3,
    ModeHeat    = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTargetTemp  = 2'd0,
    CfgRoomTemp    = 2'd1,
    CfgAcceptRange = 2'd2
  } cfg_reg_e;

  // Thermistor curve: converter count and whole degrees at each point.
  typedef logic [AdcW-1:0] tab_t [TablePoints];

  localparam tab_t LutAdc = '{
    10'd1,   10'd54,  10'd107, 10'd160, 10'd213,
    10'd266, 10'd319, 10'd372, 10'd425, 10'd478,
    10'd531, 10'd584, 10'd637, 10'd690, 10'd743,
    10'd796, 10'd849, 10'd902, 10'd955, 10'd1008
  };

  localparam tab_t LutDeg = '{
    10'd713, 10'd236, 10'd195, 10'd172, 10'd157,
    10'd144, 10'd134, 10'd125, 10'd117, 10'd110,
    10'd103, 10'd96,  10'd89,  10'd83,  10'd75,
    10'd68,  10'd59,  10'd48,  10'd34,  10'd3
  };

  // Per-segment slope coefficient: degree drop, fraction scale and reciprocal
  // of the span folded into one constant, so each sample needs one multiply.
  typedef logic [CoefW-1:0] coef_tab_t [TablePoints];

  function automatic coef_tab_t build_coef();
    coef_tab_t t;
    t[0] = '0;
    for (int k = 1; k < TablePoints; k++) begin
      t[k] = CoefW'((longint'(LutDeg[k-1]) - longint'(LutDeg[k]))
                    * (longint'(1) << FracBits) * RecipMul);
    end
    return t;
  endfunction

  localparam coef_tab_t SegCoef = build_coef();

  // Status snapshot returned for every transaction.
  typedef struct packed {
    logic             heater_on;
    logic [TempW-1:0] temperature;
    mode_e            control_mode;
    logic             sensor_fault;
    logic [DutyW-1:0] duty_high;
  } result_t;

endpackage

@@ rtl/thc_if.sv @@
// Input channel: one command with its converter sample.
interface thc_in_if;
  import thc_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [AdcW-1:0] adc_sample;

  modport source (output valid, command, adc_sample, input ready);
  modport sink   (input valid, command, adc_sample, output ready);
endinterface

// Output channel: one status transaction.
interface thc_out_if;
  import thc_pkg::*;

  logic             valid;
  logic             ready;
  logic             heater_on;
  logic [TempW-1:0] temperature;
  logic [ModeW-1:0] control_mode;
  logic             sensor_fault;
  logic [DutyW-1:0] duty_high;

  modport source (output valid, heater_on, temperature, control_mode, sensor_fault,
                  duty_high, input ready);
  modport sink   (input valid, heater_on, temperature, control_mode, sensor_fault,
                  duty_high, output ready);
endinterface

@@ rtl/thermistor_heater_controller_top.sv @@
// Thermistor heater controller.
// Input channel in_ch_i carries one command per transaction: an ADC sample
// (converted to 1/16-degree temperature through a 20-point thermistor curve),
// a control tick (advances the off/preheat/stable/cool/heat controller that
// sets the PWM duty), or a PWM tick (advances the heater PWM). Every accepted
// transaction yields exactly one status transaction on out_ch_o: heater pin,
// temperature, mode, fault flag and high count, all taken after the update.
// The status is registered at the accepting edge and is valid from the next
// cycle. Throughput is one transaction per cycle while the receiver takes
// each status; the whole update, including the single curve multiply, fits
// between the state registers and the status register.
// The status register acts as the output stage: while it holds a status the
// receiver has not taken, in_ch_i.ready is low, and it rises again in the
// cycle the receiver asserts ready, so a new command is taken in that cycle.
// Reset clears all controller state to its power-up values (mode off, duty
// 0/100, temperature 0, no fault) and drops the pending status; registers
// return to target 0, room 30 and tolerance 5. Configuration writes via
// cfg_we_i take effect at the next edge and must happen while idle.
module thermistor_heater_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [thc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [thc_pkg::CfgDataW-1:0]  cfg_data_i,
  thc_in_if.sink                        in_ch_i,
  thc_out_if.source                     out_ch_o
);
  import thc_pkg::*;

  localparam int SW = TempW + 5;
  localparam logic signed [SW-1:0] OneDeg = SW'(1) << FracBits;

  // Configuration registers.
  logic [TargetW-1:0] target_q, room_q;
  logic [AccW-1:0]    acc_q;

  // Controller state.
  mode_e              mode_q, mode_d, ctl_mode;
  logic [DutyW-1:0]   high_q, high_d, low_q, low_d;
  logic               phase_q, phase_d;
  logic [CntW-1:0]    pwm_cnt_q, pwm_cnt_d, mode_cnt_q, mode_cnt_d;
  logic [GlitchW-1:0] glitch_q, glitch_d;
  logic [TempW-1:0]   temp_q, temp_d, prev_q, prev_d;
  logic               fault_q, fault_d;

  // Output stage.
  logic    out_valid_q;
  result_t result_q, result_d;

  logic in_acc;

  // Curve interpolation.
  logic [SegW-1:0]       seg;
  logic [AdcW-1:0]       dx_full;
  logic [DxW-1:0]        dx;
  logic [CoefW+DxW-1:0]  prod;
  logic [TempW:0]        interp_sum;
  logic [TempW-1:0]      interp;

  // Controller comparisons.
  logic [TargetW-1:0]    tgt;
  logic signed [SW-1:0]  d_s, c_s, p_s, acc_s, dc, cd, cp;
  logic                  heat_req, force_off;
  logic                  preheat_cut, preheat_near, dc_gt_acc, cd_gt_acc;
  logic                  p_gt_c, p_lt_c, below_band, above_band;
  logic [CntW-1:0]       mc_inc, pwm_inc;
  logic [GlitchW-1:0]    glitch_inc;

  // The output register frees up when empty or when its status is taken.
  assign in_ch_i.ready = !out_valid_q || out_ch_o.ready;
  assign in_acc        = in_ch_i.valid && in_ch_i.ready;

  // Find the segment, then interpolate down from its upper point.
  always_comb begin
    seg = SegW'(TablePoints - 1);
    for (int k = TablePoints - 1; k >= 1; k--) begin
      if (LutAdc[k] > in_ch_i.adc_sample) begin
        seg = SegW'(k);
      end
    end
    dx_full    = LutAdc[seg] - in_ch_i.adc_sample;
    dx         = dx_full[DxW-1:0];
    prod       = (CoefW+DxW)'(SegCoef[seg]) * (CoefW+DxW)'(dx);
    interp_sum = ((TempW+1)'(LutDeg[seg]) << FracBits)
               + (TempW+1)'(prod >> RecipShift);
    interp     = interp_sum[TempW] ? {TempW{1'b1}} : interp_sum[TempW-1:0];
  end

  // Signed views of the temperatures for the controller.
  always_comb begin
    tgt          = fault_q ? '0 : target_q;
    d_s          = $signed(SW'(tgt) << FracBits);
    c_s          = $signed(SW'(temp_q));
    p_s          = $signed(SW'(prev_q));
    acc_s        = $signed(SW'(acc_q) << FracBits);
    dc           = d_s - c_s;
    cd           = c_s - d_s;
    cp           = c_s - p_s;
    heat_req     = tgt > room_q;
    force_off    = (mode_q != ModeOff) && !heat_req;
    preheat_cut  = dc < (cp <<< 2);
    preheat_near = dc < (acc_s <<< 1);
    dc_gt_acc    = dc > acc_s;
    cd_gt_acc    = cd > acc_s;
    p_gt_c       = p_s > c_s;
    p_lt_c       = p_s < c_s;
    below_band   = (d_s - OneDeg) > c_s;
    above_band   = c_s > (d_s + OneDeg);
    mc_inc       = mode_cnt_q + CntW'(1);
    pwm_inc      = pwm_cnt_q + CntW'(1);
    glitch_inc   = (glitch_q < GlitchMax) ? glitch_q + GlitchW'(1) : glitch_q;
  end

  // Next mode on a control tick.
  always_comb begin
    ctl_mode = mode_q;
    if (force_off) begin
      ctl_mode = ModeOff;
    end else begin
      unique case (mode_q)
        ModeOff: begin
          if (heat_req) ctl_mode = ModePreheat;
        end
        ModePreheat: begin
          if (preheat_near) ctl_mode = ModeStable;
          if (p_gt_c && (mc_inc > PreheatLimit)) ctl_mode = ModeHeat;
        end
        ModeStable: begin
          if (dc_gt_acc) ctl_mode = ModeHeat;
          else if (cd_gt_acc) ctl_mode = ModeCool;
        end
        ModeCool: begin
          if (!cd_gt_acc) ctl_mode = ModeStable;
        end
        ModeHeat: begin
          if (!dc_gt_acc) ctl_mode = ModeStable;
        end
        default: ctl_mode = ModeOff;
      endcase
    end
  end

  // State update for the accepted command.
  always_comb begin
    logic [DutyW-1:0] h, l;
    logic [CntW-1:0]  mc;

    mode_d     = mode_q;
    high_d     = high_q;
    low_d      = low_q;
    phase_d    = phase_q;
    pwm_cnt_d  = pwm_cnt_q;
    mode_cnt_d = mode_cnt_q;
    glitch_d   = glitch_q;
    temp_d     = temp_q;
    prev_d     = prev_q;
    fault_d    = fault_q;
    h          = high_q;
    l          = low_q;
    mc         = mode_cnt_q;

    // Duty and mode counter as the controller leaves them.
    if (force_off) begin
      h = '0;
      l = FullCount;
    end else begin
      case (mode_q)
        ModeOff: begin
          if (heat_req) begin
            h  = FullCount;
            l  = '0;
            mc = '0;
          end
        end
        ModePreheat: begin
          if (preheat_cut) begin
            h = '0;
            l = FullCount;
          end
          if (preheat_near) begin
            h = ThirdCount;
            l = FullCount - ThirdCount;
          end
          if (p_gt_c) begin
            mc = mc_inc;
            if (mc_inc > PreheatLimit) begin
              h = ThirdCount;
              l = FullCount - ThirdCount;
            end
          end else begin
            mc = '0;
          end
        end
        ModeStable: begin
          if (dc_gt_acc) begin
            if (l != '0) begin
              h = h + DutyW'(1);
              l = l - DutyW'(1);
            end
            mc = '0;
          end else if (cd_gt_acc) begin
            if (h != '0) l = l + DutyW'(1);
            h  = '0;
            mc = '0;
          end
          // Nudge the duty while the temperature drifts away from the target.
          if (p_gt_c && below_band && (l != '0)) begin
            h = h + DutyW'(1);
            l = l - DutyW'(1);
          end else if (p_lt_c && above_band && (h != '0)) begin
            h = h - DutyW'(1);
            l = l + DutyW'(1);
          end
        end
        ModeCool: begin
          h = '0;
          if (!cd_gt_acc) begin
            h = FullCount - l;
          end else if (p_lt_c) begin
            mc = mc_inc;
            if (mc_inc > CoolLimit) begin
              if (l < FullCount) l = l + DutyW'(1);
              mc = '0;
            end
          end
        end
        ModeHeat: begin
          if (!dc_gt_acc) begin
            if (h != '0) begin
              h = h - DutyW'(1);
              l = l + DutyW'(1);
            end
          end else if (p_gt_c) begin
            mc = mc_inc;
            if (mc_inc > HeatLimit) begin
              if (l != '0) begin
                h = h + DutyW'(1);
                l = l - DutyW'(1);
              end
              mc = '0;
            end
          end
        end
        default: ;
      endcase
    end

    if (in_acc) begin
      case (cmd_e'(in_ch_i.command))
        CmdAdcSample: begin
          if (in_ch_i.adc_sample >= GlitchLevel) begin
            // A glitch leaves the temperature alone; a long run latches a fault.
            glitch_d = glitch_inc;
            if (glitch_inc > GlitchLimit) fault_d = 1'b1;
          end else begin
            glitch_d = '0;
            temp_d   = interp;
            if (mode_q == ModeOff) prev_d = interp;
          end
        end
        CmdControlTick: begin
          mode_d     = ctl_mode;
          high_d     = h;
          low_d      = l;
          mode_cnt_d = mc;
          prev_d     = temp_q;
        end
        CmdPwmTick: begin
          if (!phase_q) begin
            if (high_q != '0) begin
              pwm_cnt_d = pwm_inc;
              if (pwm_inc > CntW'(low_q)) begin
                phase_d   = 1'b1;
                pwm_cnt_d = '0;
              end
            end
          end else begin
            if (low_q != '0) begin
              pwm_cnt_d = pwm_inc;
              if (pwm_inc > CntW'(high_q)) begin
                phase_d   = 1'b0;
                pwm_cnt_d = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Status snapshot after the update.
  always_comb begin
    result_d.heater_on    = phase_d;
    result_d.temperature  = temp_d;
    result_d.control_mode = mode_d;
    result_d.sensor_fault = fault_d;
    result_d.duty_high    = high_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
      room_q   <= RoomReset;
      acc_q    <= AccReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgTargetTemp:  target_q <= cfg_data_i;
        CfgRoomTemp:    room_q   <= cfg_data_i;
        CfgAcceptRange: acc_q    <= cfg_data_i[AccW-1:0];
        default: ;
      endcase
    end
  end

  // Controller state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeOff;
      high_q     <= '0;
      low_q      <= FullCount;
      phase_q    <= 1'b0;
      pwm_cnt_q  <= '0;
      mode_cnt_q <= '0;
      glitch_q   <= '0;
      temp_q     <= '0;
      prev_q     <= '0;
      fault_q    <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      high_q     <= high_d;
      low_q      <= low_d;
      phase_q    <= phase_d;
      pwm_cnt_q  <= pwm_cnt_d;
      mode_cnt_q <= mode_cnt_d;
      glitch_q   <= glitch_d;
      temp_q     <= temp_d;
      prev_q     <= prev_d;
      fault_q    <= fault_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      result_q <= result_d;
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.heater_on    = result_q.heater_on;
  assign out_ch_o.temperature  = result_q.temperature;
  assign out_ch_o.control_mode = result_q.control_mode;
  assign out_ch_o.sensor_fault = result_q.sensor_fault;
  assign out_ch_o.duty_high    = result_q.duty_high;

`ifndef SYNTH
  // The two PWM counts never add up to more than a full period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((DutyW+1)'(high_q) + (DutyW+1)'(low_q)) <= (DutyW+1)'(FullCount))
    else $error("PWM high and low counts exceed a full period");

  // The sensor fault stays latched until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fault_q |=> fault_q)
    else $error("sensor fault cleared without reset");

  // The glitch run counter saturates.
  assert property (@(posedge clk_i) disable iff (!rst_ni) glitch_q <= GlitchMax)
    else $error("glitch counter beyond saturation");

  // With heating off the heater gets no high time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeOff) |-> (high_q == '0))
    else $error("nonzero high count in off mode");

  // Every accepted command leaves a status pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> out_valid_q)
    else $error("accepted command produced no status");
`endif

endmodule
